@@ hdl/hca_pkg.sv @@
// Shared types and constants for the HLS color adjust pipeline.
`timescale 1ns / 1ps
`default_nettype none

package hca_pkg;

   localparam int CHANNEL_BITS = 8;
   localparam int CFG_BITS     = 10;
   localparam int CFG_IDX_BITS = 2;
   localparam int LUM_BITS     = 17;   // Q1.16 holding 0..1 inclusive
   localparam int DEN_BITS     = 11;   // up to 6 * 255
   localparam int QUO_BITS     = 17;
   localparam int DIV_STEPS    = 17;
   localparam int HUE_BITS     = 16;

   localparam logic [CFG_IDX_BITS-1:0] CSR_HUE_SHIFT = 2'd0;
   localparam logic [CFG_IDX_BITS-1:0] CSR_LIGHTNESS = 2'd1;
   localparam logic [CFG_IDX_BITS-1:0] CSR_SATURATION = 2'd2;

   localparam logic [16:0] Q_ONE      = 17'd65536;
   localparam logic [16:0] Q_HALF     = 17'd32768;
   localparam logic [16:0] THIRD_TURN = 17'd21845;

   typedef struct packed {
      logic [DEN_BITS-1:0] num;
      logic [DEN_BITS-1:0] den;
   } hca_div_op_type;

   typedef struct packed {
      logic [LUM_BITS-1:0] lum;
      logic                grey;
   } hca_side_type;

endpackage

`default_nettype wire

@@ hdl/hca_front.sv @@
// Front end: max/min, sum and difference, divider operands and lightness.
`timescale 1ns / 1ps
`default_nettype none

module hca_front
   import hca_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    adv,
   input  wire logic                    in_valid,
   input  wire logic [CHANNEL_BITS-1:0] red,
   input  wire logic [CHANNEL_BITS-1:0] green,
   input  wire logic [CHANNEL_BITS-1:0] blue,
   output logic                         out_valid,
   output hca_div_op_type               sat_op,
   output hca_div_op_type               hue_op,
   output hca_side_type                 side
);

   // stage 1
   logic                    s1_valid_ff;
   logic [8:0]              s1_sum_ff, s1_sum_in;
   logic [7:0]              s1_d_ff, s1_d_in;
   logic [7:0]              s1_r_ff, s1_g_ff, s1_b_ff;
   logic                    s1_rmax_ff, s1_rmax_in, s1_gmax_ff, s1_gmax_in;
   logic [7:0]              mx, mn;

   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      s1_sum_in  = {1'b0, mx} + {1'b0, mn};
      s1_d_in    = mx - mn;
      s1_rmax_in = (mx == red);
      s1_gmax_in = (mx == green);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
      end
      if (adv) begin
         s1_sum_ff  <= s1_sum_in;
         s1_d_ff    <= s1_d_in;
         s1_r_ff    <= red;
         s1_g_ff    <= green;
         s1_b_ff    <= blue;
         s1_rmax_ff <= s1_rmax_in;
         s1_gmax_ff <= s1_gmax_in;
      end
   end

   // stage 2
   logic                 s2_valid_ff;
   hca_div_op_type       sat_op_ff, sat_op_in, hue_op_ff, hue_op_in;
   hca_side_type         side_ff, side_in;
   logic [15:0]          y;
   logic [31:0]          yprod;
   logic [8:0]           lq;
   logic [16:0]          lrem;
   logic [11:0]          d12, hn12;
   logic [8:0]           den_sat;

   always_comb begin
      // sum*32768/255 = 128*sum + floor(128*sum/255)
      y     = {s1_sum_ff, 7'd0};
      yprod = 32'(y) * 32'd32897;
      lq    = 9'(yprod >> 23);
      lrem  = 17'(y) - 17'(lq) * 17'd255;
      if (lrem >= 17'd255) lq = lq + 9'd1;
      side_in.lum  = 17'(y) + 17'(lq);
      side_in.grey = (s1_d_ff == 8'd0);

      den_sat = (s1_sum_ff <= 9'd255) ? s1_sum_ff : 9'd510 - s1_sum_ff;
      sat_op_in.num = DEN_BITS'(s1_d_ff);
      sat_op_in.den = DEN_BITS'(den_sat);

      d12 = 12'(s1_d_ff);
      if (s1_rmax_ff) begin
         if (s1_g_ff >= s1_b_ff) hn12 = 12'(s1_g_ff) - 12'(s1_b_ff);
         else hn12 = 12'd6 * d12 + 12'(s1_g_ff) - 12'(s1_b_ff);
      end else if (s1_gmax_ff) begin
         hn12 = 12'd2 * d12 + 12'(s1_b_ff) - 12'(s1_r_ff);
      end else begin
         hn12 = 12'd4 * d12 + 12'(s1_r_ff) - 12'(s1_g_ff);
      end
      hue_op_in.num = hn12[DEN_BITS-1:0];
      hue_op_in.den = DEN_BITS'(12'd6 * d12);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         sat_op_ff <= sat_op_in;
         hue_op_ff <= hue_op_in;
         side_ff   <= side_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign sat_op    = sat_op_ff;
   assign hue_op    = hue_op_ff;
   assign side      = side_ff;

endmodule

`default_nettype wire

@@ hdl/hca_divider.sv @@
// Pipelined restoring divider, one quotient bit per stage, two lanes.
`timescale 1ns / 1ps
`default_nettype none

module hca_divider
   import hca_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                in_valid,
   input  wire hca_div_op_type      sat_op,
   input  wire hca_div_op_type      hue_op,
   input  wire hca_side_type        in_side,
   output logic                     out_valid,
   output logic [QUO_BITS-1:0]      sat_quo,
   output logic [QUO_BITS-1:0]      hue_quo,
   output hca_side_type             out_side
);

   // lane 0 = saturation, lane 1 = hue
   logic [DEN_BITS-1:0] rem_ff [DIV_STEPS][2];
   logic [DEN_BITS-1:0] rem_in [DIV_STEPS][2];
   logic [DEN_BITS-1:0] den_ff [DIV_STEPS][2];
   logic [DEN_BITS-1:0] den_in [DIV_STEPS][2];
   logic [QUO_BITS-1:0] quo_ff [DIV_STEPS][2];
   logic [QUO_BITS-1:0] quo_in [DIV_STEPS][2];
   hca_side_type        side_ff [DIV_STEPS];
   logic                valid_ff [DIV_STEPS];
   logic [DEN_BITS:0]   trial [DIV_STEPS][2];
   logic                ge [DIV_STEPS][2];

   always_comb begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         for (int j = 0; j < 2; j++) begin
            if (k == 0) begin
               // integer bit: no doubling
               trial[k][j]  = (j == 0) ? {1'b0, sat_op.num} : {1'b0, hue_op.num};
               den_in[k][j] = (j == 0) ? sat_op.den : hue_op.den;
            end else begin
               trial[k][j]  = {rem_ff[k-1][j], 1'b0};
               den_in[k][j] = den_ff[k-1][j];
            end
            ge[k][j]     = (trial[k][j] >= {1'b0, den_in[k][j]});
            rem_in[k][j] = ge[k][j] ? DEN_BITS'(trial[k][j] - {1'b0, den_in[k][j]})
                                    : DEN_BITS'(trial[k][j]);
            if (k == 0) quo_in[k][j] = QUO_BITS'(ge[k][j]);
            else quo_in[k][j] = {quo_ff[k-1][j][QUO_BITS-2:0], ge[k][j]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STEPS; k++) valid_ff[k] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < DIV_STEPS; k++) valid_ff[k] <= valid_ff[k-1];
      end
      if (adv) begin
         side_ff[0] <= in_side;
         for (int k = 1; k < DIV_STEPS; k++) side_ff[k] <= side_ff[k-1];
         for (int k = 0; k < DIV_STEPS; k++) begin
            for (int j = 0; j < 2; j++) begin
               rem_ff[k][j] <= rem_in[k][j];
               den_ff[k][j] <= den_in[k][j];
               quo_ff[k][j] <= quo_in[k][j];
            end
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign sat_quo   = quo_ff[DIV_STEPS-1][0];
   assign hue_quo   = quo_ff[DIV_STEPS-1][1];
   assign out_side  = side_ff[DIV_STEPS-1];

endmodule

`default_nettype wire

@@ hdl/hca_back.sv @@
// Back end: hue rotation, offsets, HLS to RGB and channel rounding.
`timescale 1ns / 1ps
`default_nettype none

module hca_back
   import hca_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    adv,
   input  wire logic                    in_valid,
   input  wire logic [QUO_BITS-1:0]     sat_quo,
   input  wire logic [QUO_BITS-1:0]     hue_quo,
   input  wire hca_side_type            side,
   input  wire logic [HUE_BITS-1:0]     hue_shift,
   input  wire logic [CFG_BITS-1:0]     light_ofs,
   input  wire logic [CFG_BITS-1:0]     sat_ofs,
   output logic                         out_valid,
   output logic [CHANNEL_BITS-1:0]      red,
   output logic [CHANNEL_BITS-1:0]      green,
   output logic [CHANNEL_BITS-1:0]      blue
);

   localparam logic [1:0] SEL_RAMP = 2'd0;
   localparam logic [1:0] SEL_Q    = 2'd1;
   localparam logic [1:0] SEL_P    = 2'd2;

   logic [5:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[4:0], in_valid};
   end

   // E: rotate hue, apply offsets
   logic [HUE_BITS-1:0] e_h_ff, e_h_in;
   logic [16:0]         e_l_ff, e_l_in, e_s_ff, e_s_in;
   logic signed [18:0]  lsum, ssum;
   logic [16:0]         sat_v, hue_v;

   function automatic logic [16:0] clamp_unit(input logic signed [18:0] v);
      logic [16:0] r;
      if (v < 0) r = '0;
      else if (v > $signed({2'b0, Q_ONE})) r = Q_ONE;
      else r = v[16:0];
      return r;
   endfunction

   always_comb begin
      sat_v  = side.grey ? '0 : sat_quo;
      hue_v  = side.grey ? '0 : hue_quo;
      e_h_in = HUE_BITS'(hue_v) + hue_shift;
      lsum   = $signed({2'b0, side.lum}) + ($signed(19'(signed'(light_ofs))) <<< 8);
      ssum   = $signed({2'b0, sat_v}) + ($signed(19'(signed'(sat_ofs))) <<< 8);
      e_l_in = clamp_unit(lsum);
      e_s_in = clamp_unit(ssum);
   end

   // F: lightness/saturation product
   logic [34:0]         f_prod_ff, f_prod_in;
   logic [16:0]         f_l_ff, f_s_ff;
   logic [HUE_BITS-1:0] f_h_ff;
   logic                f_low_ff, f_low_in;
   logic [17:0]         f_b;

   always_comb begin
      f_low_in  = (e_l_ff < Q_HALF);
      f_b       = f_low_in ? 18'(Q_ONE) + 18'(e_s_ff) : 18'(e_s_ff);
      f_prod_in = 35'(e_l_ff) * 35'(f_b);
   end

   // G: q, p and segment selection per channel
   logic [16:0]         g_diff_ff, g_diff_in, g_p_ff, g_p_in, g_q_ff, g_q_in, g_l_ff;
   logic                g_grey_ff;
   logic [16:0]         g_m_ff [3];
   logic [16:0]         g_m_in [3];
   logic [1:0]          g_sel_ff [3];
   logic [1:0]          g_sel_in [3];
   logic [18:0]         ph, q19;
   logic signed [19:0]  p20;
   logic [16:0]         t [3];
   logic [19:0]         t6 [3];

   always_comb begin
      ph  = 19'(f_prod_ff >> 16);
      q19 = f_low_ff ? ph : 19'(f_l_ff) + 19'(f_s_ff) - ph;
      g_q_in = q19[16:0];
      p20 = $signed({2'b0, f_l_ff, 1'b0}) - $signed({3'b0, g_q_in});
      g_p_in = (p20 < 0) ? '0 : p20[16:0];
      g_diff_in = g_q_in - g_p_in;

      t[0] = 17'(f_h_ff) + THIRD_TURN;
      if (t[0] > Q_ONE) t[0] = t[0] - Q_ONE;
      t[1] = 17'(f_h_ff);
      if (17'(f_h_ff) < THIRD_TURN) t[2] = 17'(f_h_ff) + Q_ONE - THIRD_TURN;
      else t[2] = 17'(f_h_ff) - THIRD_TURN;

      for (int c = 0; c < 3; c++) begin
         t6[c] = 20'(t[c]) * 20'd6;
         g_m_in[c] = '0;
         if (t6[c] < 20'(Q_ONE)) begin
            g_sel_in[c] = SEL_RAMP;
            g_m_in[c]   = t6[c][16:0];
         end else if ({t[c], 1'b0} < {1'b0, Q_ONE}) begin
            g_sel_in[c] = SEL_Q;
         end else if (19'(t[c]) * 19'd3 < 19'd131072) begin
            g_sel_in[c] = SEL_RAMP;
            g_m_in[c]   = 17'(20'd262144 - t6[c]);
         end else begin
            g_sel_in[c] = SEL_P;
         end
      end
   end

   // H: ramp products
   logic [33:0] h_prod_ff [3];
   logic [1:0]  h_sel_ff [3];
   logic [16:0] h_p_ff, h_q_ff, h_l_ff;
   logic        h_grey_ff;

   // I: channel value
   logic [17:0] i_v_ff [3];
   logic [17:0] i_v_in [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         unique case (h_sel_ff[c])
            SEL_RAMP: i_v_in[c] = 18'(h_p_ff) + 18'(h_prod_ff[c] >> 16);
            SEL_Q:    i_v_in[c] = 18'(h_q_ff);
            default:  i_v_in[c] = 18'(h_p_ff);
         endcase
         if (h_grey_ff) i_v_in[c] = 18'(h_l_ff);
      end
   end

   // J: round to channel
   logic [CHANNEL_BITS-1:0] j_c_ff [3];
   logic [CHANNEL_BITS-1:0] j_c_in [3];
   logic [25:0]             scaled [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         scaled[c] = ({i_v_ff[c], 8'd0} - 26'(i_v_ff[c]) + 26'd32768) >> 16;
         j_c_in[c] = (scaled[c] > 26'd255) ? 8'd255 : scaled[c][CHANNEL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_h_ff    <= e_h_in;
         e_l_ff    <= e_l_in;
         e_s_ff    <= e_s_in;
         f_prod_ff <= f_prod_in;
         f_l_ff    <= e_l_ff;
         f_s_ff    <= e_s_ff;
         f_h_ff    <= e_h_ff;
         f_low_ff  <= f_low_in;
         g_diff_ff <= g_diff_in;
         g_p_ff    <= g_p_in;
         g_q_ff    <= g_q_in;
         g_l_ff    <= f_l_ff;
         g_grey_ff <= (f_s_ff == '0);
         h_p_ff    <= g_p_ff;
         h_q_ff    <= g_q_ff;
         h_l_ff    <= g_l_ff;
         h_grey_ff <= g_grey_ff;
         for (int c = 0; c < 3; c++) begin
            g_m_ff[c]    <= g_m_in[c];
            g_sel_ff[c]  <= g_sel_in[c];
            h_prod_ff[c] <= 34'(g_diff_ff) * 34'(g_m_ff[c]);
            h_sel_ff[c]  <= g_sel_ff[c];
            i_v_ff[c]    <= i_v_in[c];
            j_c_ff[c]    <= j_c_in[c];
         end
      end
   end

   assign out_valid = vld_ff[5];
   assign red       = j_c_ff[0];
   assign green     = j_c_ff[1];
   assign blue      = j_c_ff[2];

endmodule

`default_nettype wire

@@ hdl/hls_color_adjust_unit.sv @@
// Top level of the HLS color adjust unit: configuration, hue shift and pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Converts each RGB pixel to HLS, rotates the hue, offsets lightness and
// saturation, and converts back. Fully pipelined: one pixel per clock unless
// the output is stalled, through 2 front stages, 17 divider stages (one
// quotient bit each) and 6 back stages, the last of which is the output
// register. The whole pipeline advances together; when the output is stalled,
// req_stall is raised and nothing moves. Configuration writes take effect for
// pixels as they enter back stage E, the hue shift after its own registers.

module hls_color_adjust_unit
   import hca_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [CHANNEL_BITS-1:0] req_red_in,
   input  wire logic [CHANNEL_BITS-1:0] req_green_in,
   input  wire logic [CHANNEL_BITS-1:0] req_blue_in,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [CHANNEL_BITS-1:0]      rsp_red_out,
   output logic [CHANNEL_BITS-1:0]      rsp_green_out,
   output logic [CHANNEL_BITS-1:0]      rsp_blue_out,
   input  wire logic                    csr_write_enable,
   input  wire logic [CFG_IDX_BITS-1:0] csr_index,
   input  wire logic [CFG_BITS-1:0]     csr_write_data
);

   logic [CFG_BITS-1:0] hue_cfg_ff, light_cfg_ff, sat_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_cfg_ff   <= '0;
         light_cfg_ff <= '0;
         sat_cfg_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HUE_SHIFT:  hue_cfg_ff   <= csr_write_data;
            CSR_LIGHTNESS:  light_cfg_ff <= csr_write_data;
            CSR_SATURATION: sat_cfg_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // hue shift = floor(deg*65536/360) = 182*deg + floor(2*deg/45)
   logic [8:0]           deg_ff, deg_in;
   logic signed [10:0]   degs;
   logic [15:0]          base_ff;
   logic [9:0]           z_ff;
   logic [4:0]           zq_ff, zq_c;
   logic [25:0]          zprod;
   logic [HUE_BITS-1:0]  shift_ff;

   always_comb begin
      degs = 11'(signed'(hue_cfg_ff));
      if (degs < -11'sd360) deg_in = 9'(degs + 11'sd720);
      else if (degs < 0) deg_in = 9'(degs + 11'sd360);
      else if (degs >= 11'sd360) deg_in = 9'(degs - 11'sd360);
      else deg_in = degs[8:0];
      zprod = 26'({deg_ff, 1'b0}) * 26'd1457;
      zq_c  = (10'(zq_ff) * 10'd45 > z_ff) ? zq_ff - 5'd1 : zq_ff;
   end

   always_ff @(posedge clock) begin
      deg_ff   <= deg_in;
      base_ff  <= 16'(deg_ff) * 16'd182;
      z_ff     <= {deg_ff, 1'b0};
      zq_ff    <= 5'(zprod >> 16);
      shift_ff <= base_ff + 16'(zq_c);
   end

   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   logic           fr_valid, dv_valid;
   hca_div_op_type sat_op, hue_op;
   hca_side_type   fr_side, dv_side;
   logic [QUO_BITS-1:0] sat_quo, hue_quo;

   hca_front u_front (
      .clock, .reset, .adv,
      .in_valid (req_valid),
      .red      (req_red_in),
      .green    (req_green_in),
      .blue     (req_blue_in),
      .out_valid(fr_valid),
      .sat_op,
      .hue_op,
      .side     (fr_side)
   );

   hca_divider u_divider (
      .clock, .reset, .adv,
      .in_valid (fr_valid),
      .sat_op,
      .hue_op,
      .in_side  (fr_side),
      .out_valid(dv_valid),
      .sat_quo,
      .hue_quo,
      .out_side (dv_side)
   );

   hca_back u_back (
      .clock, .reset, .adv,
      .in_valid (dv_valid),
      .sat_quo,
      .hue_quo,
      .side     (dv_side),
      .hue_shift(shift_ff),
      .light_ofs(light_cfg_ff),
      .sat_ofs  (sat_cfg_ff),
      .out_valid(rsp_valid),
      .red      (rsp_red_out),
      .green    (rsp_green_out),
      .blue     (rsp_blue_out)
   );

`ifndef SYNTHESIS
   a_stall_only_on_full_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

   a_no_valid_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_deg_wrapped: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (deg_ff < 9'd360))
      else $error("hue rotation not wrapped into one turn");
`endif

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the HLS color adjust unit.
`timescale 1ns / 1ps

module tb;
   import hca_pkg::*;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct {
      pixel_type pix;
      bit        known;
      pixel_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_red_in = '0, req_green_in = '0, req_blue_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic csr_write_enable = 1'b0;
   logic [CFG_IDX_BITS-1:0] csr_index = CSR_HUE_SHIFT;
   logic [CFG_BITS-1:0] csr_write_data = '0;

   hls_color_adjust_unit dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic signed [9:0] hue_deg_reg, light_ofs_reg, sat_ofs_reg;
   pixel_type adjusted_q[$];
   int errors = 0;
   int cycles = 0;
   bit sending = 1'b0;
   bit stim_done = 1'b0;
   localparam int CYCLE_LIMIT = 600000;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic longint unit_clamp(longint v);
      if (v < 0) return 0;
      if (v > 65536) return 65536;
      return v;
   endfunction

   function automatic longint turn_level(longint p, longint q, longint t);
      if (t < 0) t += 65536;
      if (t > 65536) t -= 65536;
      if (6 * t < 65536) return p + (((q - p) * 6 * t) >>> 16);
      if (2 * t < 65536) return q;
      if (3 * t < 131072) return p + (((q - p) * (262144 - 6 * t)) >>> 16);
      return p;
   endfunction

   function automatic logic [7:0] level_to_byte(longint v);
      longint c;
      if (v < 0) v = 0;
      c = (v * 255 + 32768) >>> 16;
      if (c > 255) c = 255;
      return c[7:0];
   endfunction

   function automatic pixel_type adjust_pixel(pixel_type px);
      longint r, g, b, mx, mn, sum, d, lum, sat, hue, hn, deg, h, l, s, q, p;
      pixel_type o;
      r = px.red; g = px.green; b = px.blue;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      sum = mx + mn; d = mx - mn;
      lum = (sum * 32768) / 255;
      sat = 0; hue = 0;
      if (d > 0) begin
         if (sum <= 255) sat = (d * 65536) / sum;
         else sat = (d * 65536) / (510 - sum);
         if (mx == r) hn = (g - b) + ((g < b) ? 6 * d : 0);
         else if (mx == g) hn = 2 * d + b - r;
         else hn = 4 * d + r - g;
         hue = (hn * 65536) / (6 * d);
      end
      deg = longint'(hue_deg_reg) % 360;
      if (deg < 0) deg += 360;
      h = (hue + (deg * 65536) / 360) & 65535;
      l = unit_clamp(lum + 256 * longint'(light_ofs_reg));
      s = unit_clamp(sat + 256 * longint'(sat_ofs_reg));
      if (s == 0) begin
         o.red = level_to_byte(l); o.green = o.red; o.blue = o.red;
      end else begin
         if (l < 32768) q = (l * (65536 + s)) >>> 16;
         else q = l + s - ((l * s) >>> 16);
         p = 2 * l - q;
         if (p < 0) p = 0;
         o.red   = level_to_byte(turn_level(p, q, h + 21845));
         o.green = level_to_byte(turn_level(p, q, h));
         o.blue  = level_to_byte(turn_level(p, q, h - 21845));
      end
      return o;
   endfunction

   // expected results get queued at acceptance
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         adjusted_q.push_back(adjust_pixel('{req_red_in, req_green_in, req_blue_in}));
   end

   pixel_type fixed_q[$];
   bit fixed_known_q[$];

   always @(posedge clock) begin
      pixel_type exp_pix;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (adjusted_q.size() == 0) begin
            $error("result transaction with nothing expected");
            errors++;
         end else begin
            exp_pix = adjusted_q.pop_front();
            if (rsp_red_out !== exp_pix.red) begin
               $error("red_out expected %0d got %0d", exp_pix.red, rsp_red_out); errors++;
            end
            if (rsp_green_out !== exp_pix.green) begin
               $error("green_out expected %0d got %0d", exp_pix.green, rsp_green_out);
               errors++;
            end
            if (rsp_blue_out !== exp_pix.blue) begin
               $error("blue_out expected %0d got %0d", exp_pix.blue, rsp_blue_out);
               errors++;
            end
            if (fixed_q.size() > 0) begin
               if (fixed_known_q[0] && (rsp_red_out !== fixed_q[0].red ||
                   rsp_green_out !== fixed_q[0].green || rsp_blue_out !== fixed_q[0].blue)) begin
                  $error("table row expected %0d/%0d/%0d got %0d/%0d/%0d", fixed_q[0].red,
                         fixed_q[0].green, fixed_q[0].blue, rsp_red_out, rsp_green_out,
                         rsp_blue_out);
                  errors++;
               end
               void'(fixed_q.pop_front());
               void'(fixed_known_q.pop_front());
            end
         end
      end
   end

   // receiver stall pattern
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if ($urandom_range(0, 7) == 0) gap = 0;
         repeat (gap) begin
            @(posedge clock);
            rsp_stall <= 1'b1;
         end
         @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // returns at the accepting edge with valid still high, so a zero gap
   // gives back-to-back transactions
   task automatic send_pixel(pixel_type px, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red_in <= px.red; req_green_in <= px.green; req_blue_in <= px.blue;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (adjusted_q.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [CFG_IDX_BITS-1:0] idx, logic [9:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1; csr_index <= idx; csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_HUE_SHIFT:  hue_deg_reg = val;
         CSR_LIGHTNESS:  light_ofs_reg = val;
         CSR_SATURATION: sat_ofs_reg = val;
         default: ;
      endcase
   endtask

   task automatic random_phase(int n);
      pixel_type px;
      int gap;
      for (int i = 0; i < n; i++) begin
         px.red = $urandom; px.green = $urandom; px.blue = $urandom;
         if ($urandom_range(0, 9) == 0) begin
            px.green = px.red; px.blue = px.red;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
         send_pixel(px, gap);
      end
   endtask

   stim_row_type table_rows[$];

   initial begin
      logic [9:0] hue_set[];
      logic [9:0] ofs_set[];
      hue_set = '{10'sd0, 10'sd359, -10'sd359, 10'sd120, -10'sd90, 10'sd511,
                  -10'sd512, 10'sd180};
      ofs_set = '{10'sd0, 10'sd256, -10'sd256, 10'sd511, -10'sd512, 10'sd37,
                  -10'sd64, 10'sd128};
      hue_deg_reg = 0; light_ofs_reg = 0; sat_ofs_reg = 0;
      // black, white, mid grey and red: exact after reset; other rows have no fixed value
      table_rows = '{
         '{'{8'd0, 8'd0, 8'd0}, 1, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd255, 8'd255, 8'd255}, 1, '{8'd255, 8'd255, 8'd255}},
         '{'{8'd128, 8'd128, 8'd128}, 1, '{8'd128, 8'd128, 8'd128}},
         '{'{8'd255, 8'd0, 8'd0}, 1, '{8'd255, 8'd0, 8'd0}},
         '{'{8'd0, 8'd255, 8'd0}, 0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd0, 8'd0, 8'd255}, 0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd255, 8'd255, 8'd0}, 0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd0, 8'd255, 8'd255}, 0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd255, 8'd0, 8'd255}, 0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd1, 8'd0, 8'd2}, 0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd254, 8'd255, 8'd253}, 0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd10, 8'd200, 8'd90}, 0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd170, 8'd85, 8'd85}, 0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd85, 8'd170, 8'd255}, 0, '{8'd0, 8'd0, 8'd0}}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (table_rows[i]) begin
         fixed_q.push_back(table_rows[i].want);
         fixed_known_q.push_back(table_rows[i].known);
         send_pixel(table_rows[i].pix, $urandom_range(0, 2));
      end
      drain_pipe();
      // grey with offsets, and saturation forced to zero
      write_csr(CSR_HUE_SHIFT, 10'sd200);
      write_csr(CSR_LIGHTNESS, 10'sd40);
      write_csr(CSR_SATURATION, -10'sd256);
      send_pixel('{8'd100, 8'd100, 8'd100}, 0);
      send_pixel('{8'd200, 8'd30, 8'd60}, 0);
      send_pixel('{8'd255, 8'd255, 8'd255}, 1);
      drain_pipe();
      random_phase(150);
      drain_pipe();
      for (int ph = 0; ph < 10; ph++) begin
         write_csr(CSR_HUE_SHIFT, (ph < 8) ? hue_set[ph] : 10'($urandom));
         write_csr(CSR_LIGHTNESS, (ph < 8) ? ofs_set[ph] : 10'($urandom));
         write_csr(CSR_SATURATION, (ph < 8) ? ofs_set[7 - ph] : 10'($urandom));
         if ($urandom_range(0, 3) == 0) write_csr(2'd3, 10'($urandom));
         random_phase(155);
         drain_pipe();
      end
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ hls_color_adjust_unit.f @@
hdl/hca_pkg.sv
hdl/hca_front.sv
hdl/hca_divider.sv
hdl/hca_back.sv
hdl/hls_color_adjust_unit.sv
verif/tb.sv
